>>> design/rectangle_overlay_grid_assert.svh
// Assertion macros used by the checker module of the grid block.
`ifndef RECTANGLE_OVERLAY_GRID_ASSERT_SVH
`define RECTANGLE_OVERLAY_GRID_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ROG_ASSERT_NOW(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("rectangle_overlay_grid: check failed");

// The consequent must hold in the cycle after the antecedent.
`define ROG_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("rectangle_overlay_grid: check failed");

`endif

>>> design/rog_pkg.sv
`default_nettype none

package rog_pkg;

    localparam int ROWS_DEF  = 64;
    localparam int COLS_DEF  = 64;
    localparam int LOG_DEF   = 32;

    localparam int COORD_W   = 6;
    localparam int DATA_W    = 32;
    localparam int SIZE_W    = 7;
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;
    localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(64);

    localparam logic [1:0] MODE_WRITE = 2'd0;
    localparam logic [1:0] MODE_PUSH  = 2'd1;
    localparam logic [1:0] MODE_READ  = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    localparam logic REG_ROWS = 1'b0;
    localparam logic REG_COLS = 1'b1;

    typedef struct packed {
        logic [COORD_W-1:0]       top;
        logic [COORD_W-1:0]       left;
        logic [COORD_W-1:0]       bottom;
        logic [COORD_W-1:0]       right;
        logic signed [DATA_W-1:0] value;
    } entry_t;

    typedef struct packed {
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
    } query_t;

    typedef struct packed {
        logic                     hit;
        logic signed [DATA_W-1:0] value;
    } link_t;

endpackage

`default_nettype wire

>>> design/rog_ram.sv
`default_nettype none

module rog_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             en,
    input  wire logic             we,
    input  wire logic [AW-1:0]    addr,
    input  wire logic [WIDTH-1:0] wdata,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem_reg[addr] <= wdata;
            end
            else
            begin
                rdata <= mem_reg[addr];
            end
        end
    end

endmodule

`default_nettype wire

>>> design/rog_cell.sv
`default_nettype none

module rog_cell (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire logic            valid_in,
    input  wire rog_pkg::entry_t entry_in,
    output logic                 valid_out,
    output rog_pkg::entry_t      entry_out,
    input  wire logic            query_load,
    input  wire rog_pkg::query_t query,
    input  wire rog_pkg::link_t  link_in,
    output rog_pkg::link_t       link_out
);

    import rog_pkg::*;

    logic   valid_reg;
    entry_t entry_reg;
    logic   hit_reg;
    logic   hit_next;

    // A push moves every entry one cell towards the old end of the chain.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            hit_reg   <= 1'b0;
        end
        else
        begin
            if (push)
            begin
                valid_reg <= valid_in;
            end
            if (query_load)
            begin
                hit_reg <= hit_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg <= entry_in;
        end
    end

    always_comb
    begin
        hit_next = valid_reg
                && (entry_reg.top  <= query.row) && (query.row <= entry_reg.bottom)
                && (entry_reg.left <= query.col) && (query.col <= entry_reg.right);
    end

    // Newer cells sit upstream, so a hit arriving from upstream wins.
    always_comb
    begin
        if (link_in.hit)
        begin
            link_out = link_in;
        end
        else
        begin
            link_out.hit   = hit_reg;
            link_out.value = entry_reg.value;
        end
    end

    assign valid_out = valid_reg;
    assign entry_out = entry_reg;

endmodule

`default_nettype wire

>>> design/rectangle_overlay_grid.sv
// An accepted item moves to the S_LOOK state, and its result is loaded into the output
// registers from there once the output is not stalled; no new item is taken until then.
// The grid memory's registered read and each log cell's registered compare call for S_LOOK.
// Reset (asynchronous, active low) empties the update log, sets both size
// registers to 64 and leaves the grid memory uncleared, with no clearing pass.
`default_nettype none

module rectangle_overlay_grid #(
    parameter int GRID_ROWS = rog_pkg::ROWS_DEF,
    parameter int GRID_COLS = rog_pkg::COLS_DEF,
    parameter int LOG_DEPTH = rog_pkg::LOG_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,

    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [1:0]                    mode,
    input  wire logic [rog_pkg::COORD_W-1:0]   row_a,
    input  wire logic [rog_pkg::COORD_W-1:0]   col_a,
    input  wire logic [rog_pkg::COORD_W-1:0]   row_b,
    input  wire logic [rog_pkg::COORD_W-1:0]   col_b,
    input  wire logic signed [rog_pkg::DATA_W-1:0] data_in,

    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic signed [rog_pkg::DATA_W-1:0]  data_out,
    output logic [1:0]                         status,
    output logic                               from_update,

    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [rog_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [rog_pkg::PDATA_W-1:0]   pwdata,
    output logic      [rog_pkg::PDATA_W-1:0]   prdata,
    output logic                               pready
);

    import rog_pkg::*;

    localparam int CELLS = GRID_ROWS * GRID_COLS;
    localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int CW    = $clog2(LOG_DEPTH + 1);
    localparam logic [CW-1:0] COUNT_FULL = CW'(LOG_DEPTH);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_LOOK = 1'b1;

    logic              state_reg, state_next;
    logic [SIZE_W-1:0] rows_reg, cols_reg;
    logic [CW-1:0]     count_reg;
    logic [1:0]        op_mode_reg;
    logic [1:0]        op_status_reg;
    logic [1:0]        status_next;
    logic              out_valid_reg;
    logic signed [DATA_W-1:0] data_out_reg;
    logic [1:0]        status_reg;
    logic              from_update_reg;

    logic              accept, cfg_write, load_out;
    logic              ok_a, ok_b;
    logic              do_push, ram_en, ram_we;
    logic [AW-1:0]     ram_addr;
    logic [DATA_W-1:0] ram_rdata;
    entry_t            new_entry;
    query_t            query;
    logic              read_ok;

    logic              cell_valid [LOG_DEPTH];
    entry_t            cell_entry [LOG_DEPTH];
    link_t             cell_link  [LOG_DEPTH];

    assign accept    = in_valid && !in_stall;
    assign in_stall  = (state_reg != S_IDLE);
    assign cfg_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;

    always_comb
    begin
        prdata = '0;
        unique case (paddr[2])
            REG_ROWS: prdata = PDATA_W'(rows_reg);
            REG_COLS: prdata = PDATA_W'(cols_reg);
            default:  prdata = '0;
        endcase
    end

    // A size register above the grid dimension is clipped by the second compare.
    assign ok_a = (row_a < rows_reg) && (int'(row_a) < GRID_ROWS)
               && (col_a < cols_reg) && (int'(col_a) < GRID_COLS);
    assign ok_b = (row_b < rows_reg) && (int'(row_b) < GRID_ROWS)
               && (col_b < cols_reg) && (int'(col_b) < GRID_COLS);

    always_comb
    begin
        status_next = ST_OK;
        do_push     = 1'b0;
        ram_en      = 1'b0;
        ram_we      = 1'b0;
        unique case (mode)
            MODE_WRITE:
            begin
                status_next = ok_a ? ST_OK : ST_RANGE;
                ram_en      = accept && ok_a;
                ram_we      = 1'b1;
            end
            MODE_PUSH:
            begin
                priority if (!(ok_a && ok_b))
                begin
                    status_next = ST_RANGE;
                end
                else if (count_reg >= COUNT_FULL)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    do_push = accept;
                end
            end
            MODE_READ:
            begin
                status_next = ok_a ? ST_OK : ST_RANGE;
                ram_en      = accept && ok_a;
            end
            default:
            begin
                status_next = ST_OK;
            end
        endcase
    end

    assign ram_addr = AW'(int'(row_a) * GRID_COLS + int'(col_a));

    rog_ram #(
        .WIDTH (DATA_W),
        .DEPTH (CELLS),
        .AW    (AW)
    ) u_grid (
        .clk   (clk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (data_in),
        .rdata (ram_rdata)
    );

    assign new_entry = '{top: row_a, left: col_a, bottom: row_b, right: col_b,
                         value: data_in};
    assign query     = '{row: row_a, col: col_a};

    for (genvar i = 0; i < LOG_DEPTH; i++)
    begin : g_cell
        logic   up_valid;
        entry_t up_entry;
        link_t  up_link;

        if (i == 0)
        begin : g_head
            assign up_valid = 1'b1;
            assign up_entry = new_entry;
            assign up_link  = '0;
        end
        else
        begin : g_body
            assign up_valid = cell_valid[i-1];
            assign up_entry = cell_entry[i-1];
            assign up_link  = cell_link[i-1];
        end

        rog_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .push       (do_push),
            .valid_in   (up_valid),
            .entry_in   (up_entry),
            .valid_out  (cell_valid[i]),
            .entry_out  (cell_entry[i]),
            .query_load (accept),
            .query      (query),
            .link_in    (up_link),
            .link_out   (cell_link[i])
        );
    end

    assign load_out = (state_reg == S_LOOK) && (!out_valid_reg || !out_stall);
    assign read_ok  = (op_mode_reg == MODE_READ) && (op_status_reg == ST_OK);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  state_next = accept ? S_LOOK : S_IDLE;
            S_LOOK:  state_next = load_out ? S_IDLE : S_LOOK;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rows_reg      <= SIZE_RESET;
            cols_reg      <= SIZE_RESET;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_write)
            begin
                unique case (paddr[2])
                    REG_ROWS: rows_reg <= pwdata[SIZE_W-1:0];
                    REG_COLS: cols_reg <= pwdata[SIZE_W-1:0];
                    default:  rows_reg <= rows_reg;
                endcase
            end
            if (do_push)
            begin
                count_reg <= count_reg + CW'(1);
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_mode_reg   <= mode;
            op_status_reg <= status_next;
        end
        if (load_out)
        begin
            status_reg      <= op_status_reg;
            from_update_reg <= read_ok && cell_link[LOG_DEPTH-1].hit;
            if (!read_ok)
            begin
                data_out_reg <= '0;
            end
            else if (cell_link[LOG_DEPTH-1].hit)
            begin
                data_out_reg <= cell_link[LOG_DEPTH-1].value;
            end
            else
            begin
                data_out_reg <= ram_rdata;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign data_out    = data_out_reg;
    assign status      = status_reg;
    assign from_update = from_update_reg;

endmodule

`default_nettype wire

>>> design/rog_checker.sv
`default_nettype none
`include "rectangle_overlay_grid_assert.svh"

module rog_checker (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    input  wire logic                              in_stall,
    input  wire logic                              out_valid,
    input  wire logic                              out_stall,
    input  wire logic signed [rog_pkg::DATA_W-1:0] data_out,
    input  wire logic [1:0]                        status,
    input  wire logic                              from_update
);

    import rog_pkg::*;

    // A held result keeps its beat.
    `ROG_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(data_out))

    // One item is worked on at a time, so an accepted beat stalls the next cycle.
    `ROG_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)

    `ROG_ASSERT_NOW(a_hit_is_ok, out_valid && from_update, status == ST_OK)

    `ROG_ASSERT_NOW(a_error_zero, out_valid && status != ST_OK,
                    data_out == '0 && !from_update)

endmodule

bind rectangle_overlay_grid rog_checker u_rog_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .data_out    (data_out),
    .status      (status),
    .from_update (from_update)
);

`default_nettype wire

>>> tb/sv/rectangle_overlay_grid_checker.sv
module rectangle_overlay_grid_checker (
    input  logic                              clk,
    input  logic                              rst_n,

    input  logic                              in_valid,
    input  logic                              in_stall,
    input  logic [1:0]                        mode,
    input  logic [rog_pkg::COORD_W-1:0]       row_a,
    input  logic [rog_pkg::COORD_W-1:0]       col_a,
    input  logic [rog_pkg::COORD_W-1:0]       row_b,
    input  logic [rog_pkg::COORD_W-1:0]       col_b,
    input  logic [rog_pkg::DATA_W-1:0]        data_in,

    input  logic                              out_valid,
    input  logic                              out_stall,
    input  logic [rog_pkg::DATA_W-1:0]        data_out,
    input  logic [1:0]                        status,
    input  logic                              from_update,

    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic                              pready,
    input  logic [rog_pkg::PADDR_W-1:0]       paddr,
    input  logic [rog_pkg::PDATA_W-1:0]       pwdata,

    output int                                mismatches,
    output int                                pending
);

    import rog_pkg::*;

    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic [1:0]        code;
        logic              hit;
    } cell_result_t;

    logic [SIZE_W-1:0] rows_cfg;
    logic [SIZE_W-1:0] cols_cfg;
    logic [DATA_W-1:0] grid_copy [0:ROWS_DEF*COLS_DEF-1];
    entry_t            rect_log [0:LOG_DEF-1];
    int                rect_count;
    cell_result_t      awaited_cells [$];
    cell_result_t      want;
    cell_result_t      got;

    function automatic int clip_size(logic [SIZE_W-1:0] v, int lim);
        return (int'(v) > lim) ? lim : int'(v);
    endfunction

    function automatic bit on_grid(logic [COORD_W-1:0] r, logic [COORD_W-1:0] c);
        return int'(r) < clip_size(rows_cfg, ROWS_DEF) && int'(c) < clip_size(cols_cfg, COLS_DEF);
    endfunction

    // Updates the shadow grid and rectangle log, and returns what the block must answer.
    function automatic cell_result_t apply_command(
        logic [1:0]         op,
        logic [COORD_W-1:0] ra,
        logic [COORD_W-1:0] ca,
        logic [COORD_W-1:0] rb,
        logic [COORD_W-1:0] cb,
        logic [DATA_W-1:0]  din
    );
        cell_result_t res;
        res = '0;
        case (op)
            MODE_WRITE: begin
                if (!on_grid(ra, ca))
                    res.code = ST_RANGE;
                else
                    grid_copy[{ra, ca}] = din;
            end
            MODE_PUSH: begin
                // The range check on both given corners wins over a full log.
                if (!on_grid(ra, ca) || !on_grid(rb, cb))
                    res.code = ST_RANGE;
                else if (rect_count >= LOG_DEF)
                    res.code = ST_FULL;
                else
                begin
                    rect_log[rect_count] = '{top: ra, left: ca, bottom: rb, right: cb,
                                             value: din};
                    rect_count++;
                end
            end
            MODE_READ: begin
                if (!on_grid(ra, ca))
                    res.code = ST_RANGE;
                else
                begin
                    for (int i = rect_count - 1; i >= 0; i--)
                    begin
                        if (!res.hit && rect_log[i].top <= ra && ra <= rect_log[i].bottom &&
                            rect_log[i].left <= ca && ca <= rect_log[i].right)
                        begin
                            res.hit   = 1'b1;
                            res.value = rect_log[i].value;
                        end
                    end
                    if (!res.hit)
                        res.value = grid_copy[{ra, ca}];
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    initial
    begin
        mismatches = 0;
        pending    = 0;
        rows_cfg   = SIZE_RESET;
        cols_cfg   = SIZE_RESET;
        rect_count = 0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_cfg   = SIZE_RESET;
            cols_cfg   = SIZE_RESET;
            rect_count = 0;
            for (int i = 0; i < LOG_DEF; i++)
                rect_log[i] = '0;
            awaited_cells.delete();
            pending = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                if (paddr[PADDR_W-1:2] == REG_ROWS)
                    rows_cfg = pwdata[SIZE_W-1:0];
                else if (paddr[PADDR_W-1:2] == REG_COLS)
                    cols_cfg = pwdata[SIZE_W-1:0];
            end

            // Results are checked before the new command is queued: the block registers each
            // result, so a result beat can never belong to the command of the same edge.
            if (out_valid && !out_stall)
            begin
                got = '{value: data_out, code: status, hit: from_update};
                if (awaited_cells.size() == 0)
                begin
                    $display("%0t: unexpected result beat: data_out %h status %0d from_update %0d",
                             $time, data_out, status, from_update);
                    mismatches++;
                end
                else
                begin
                    want = awaited_cells.pop_front();
                    if (got.value !== want.value)
                    begin
                        $display("%0t: data_out expected %h, got %h", $time, want.value,
                                 got.value);
                        mismatches++;
                    end
                    if (got.code !== want.code)
                    begin
                        $display("%0t: status expected %0d, got %0d", $time, want.code,
                                 got.code);
                        mismatches++;
                    end
                    if (got.hit !== want.hit)
                    begin
                        $display("%0t: from_update expected %0d, got %0d", $time, want.hit,
                                 got.hit);
                        mismatches++;
                    end
                end
            end

            if (in_valid && !in_stall)
                awaited_cells.insert(awaited_cells.size(),
                                     apply_command(mode, row_a, col_a, row_b, col_b,
                                                   data_in));
            pending = awaited_cells.size();
        end
    end

endmodule

>>> tb/sv/rectangle_overlay_grid_test.sv
module rectangle_overlay_grid_test;

    import rog_pkg::*;

    localparam logic [1:0]         MODE_UNUSED    = 2'd3;
    localparam int                 GRID_EDGE      = 64;
    localparam int                 LONG_HOLD      = 150;
    localparam int                 HOLD_AT_BEAT   = 700;
    localparam int                 WATCHDOG_LIMIT = 3000;
    localparam logic [COORD_W-1:0] TOP_COORD      = '1;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;

    logic                      in_valid = 1'b0;
    logic                      in_stall;
    logic [1:0]                mode = MODE_WRITE;
    logic [COORD_W-1:0]        row_a = '0;
    logic [COORD_W-1:0]        col_a = '0;
    logic [COORD_W-1:0]        row_b = '0;
    logic [COORD_W-1:0]        col_b = '0;
    logic [DATA_W-1:0]         data_in = '0;

    logic                      out_valid;
    logic                      out_stall = 1'b0;
    logic [DATA_W-1:0]         data_out;
    logic [1:0]                status;
    logic                      from_update;

    logic                      psel = 1'b0;
    logic                      penable = 1'b0;
    logic                      pwrite = 1'b0;
    logic [PADDR_W-1:0]        paddr = '0;
    logic [PDATA_W-1:0]        pwdata = '0;
    logic [PDATA_W-1:0]        prdata;
    logic                      pready;

    int                        mismatches;
    int                        pending;

    // Stimulus shaping only: which cells hold a value and how many rectangles went in.
    int                        rows_eff = GRID_EDGE;
    int                        cols_eff = GRID_EDGE;
    int                        beats_sent = 0;
    int                        rects_logged = 0;
    bit                        cell_seen [0:ROWS_DEF*COLS_DEF-1];
    logic [2*COORD_W-1:0]      written_cells [$];

    always #2 clk = ~clk;

    rectangle_overlay_grid u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .mode        (mode),
        .row_a       (row_a),
        .col_a       (col_a),
        .row_b       (row_b),
        .col_b       (col_b),
        .data_in     (data_in),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .data_out    (data_out),
        .status      (status),
        .from_update (from_update),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    rectangle_overlay_grid_checker u_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .mode        (mode),
        .row_a       (row_a),
        .col_a       (col_a),
        .row_b       (row_b),
        .col_b       (col_b),
        .data_in     (data_in),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .data_out    (data_out),
        .status      (status),
        .from_update (from_update),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .pready      (pready),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .mismatches  (mismatches),
        .pending     (pending)
    );

    function automatic bit fits_now(logic [COORD_W-1:0] r, logic [COORD_W-1:0] c);
        return int'(r) < rows_eff && int'(c) < cols_eff;
    endfunction

    function automatic logic [COORD_W-1:0] pick_inside(int lim);
        return COORD_W'($urandom_range(lim - 1, 0));
    endfunction

    function automatic logic [COORD_W-1:0] pick_outside(int lim);
        return COORD_W'($urandom_range(GRID_EDGE - 1, lim));
    endfunction

    function automatic logic [DATA_W-1:0] random_word();
        case ($urandom_range(7, 0))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'hFFFF_FFFF;
            3:       return 32'h0000_0000;
            default: return DATA_W'($urandom());
        endcase
    endfunction

    // One coordinate of the pair lands at or beyond the size in use.
    task automatic outside_pair(output logic [COORD_W-1:0] r, output logic [COORD_W-1:0] c);
        if (rows_eff < GRID_EDGE && (cols_eff == GRID_EDGE || $urandom_range(1, 0) == 1))
        begin
            r = pick_outside(rows_eff);
            c = COORD_W'($urandom());
        end
        else
        begin
            c = pick_outside(cols_eff);
            r = COORD_W'($urandom());
        end
    endtask

    task automatic send_beat(
        input logic [1:0]         op,
        input logic [COORD_W-1:0] ra,
        input logic [COORD_W-1:0] ca,
        input logic [COORD_W-1:0] rb,
        input logic [COORD_W-1:0] cb,
        input logic [DATA_W-1:0]  din
    );
        @(negedge clk);
        in_valid <= 1'b1;
        mode     <= op;
        row_a    <= ra;
        col_a    <= ca;
        row_b    <= rb;
        col_b    <= cb;
        data_in  <= din;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        beats_sent++;
        if (op == MODE_WRITE && fits_now(ra, ca) && !cell_seen[{ra, ca}])
        begin
            cell_seen[{ra, ca}] = 1'b1;
            written_cells.insert(written_cells.size(), {ra, ca});
        end
        if (op == MODE_PUSH && fits_now(ra, ca) && fits_now(rb, cb))
            rects_logged++;
    endtask

    task automatic sender_pause();
        int gap;
        int pick;
        pick = $urandom_range(99, 0);
        if ((beats_sent % 160) < 40)
            gap = 0;
        else if (pick < 45)
            gap = 0;
        else if (pick < 80)
            gap = $urandom_range(3, 1);
        else if (pick < 95)
            gap = $urandom_range(10, 4);
        else
            gap = $urandom_range(40, 15);
        repeat (gap)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
    endtask

    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    task automatic write_register(input logic idx, input int value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= PDATA_W'(value);
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_ROWS)
            rows_eff = (value > GRID_EDGE) ? GRID_EDGE : value;
        else
            cols_eff = (value > GRID_EDGE) ? GRID_EDGE : value;
    endtask

    task automatic configure(input int rows, input int cols);
        wait_drained();
        repeat (3) @(negedge clk);
        write_register(REG_ROWS, rows);
        write_register(REG_COLS, cols);
    endtask

    task automatic random_beat();
        logic [1:0]           op;
        logic [COORD_W-1:0]   ra;
        logic [COORD_W-1:0]   ca;
        logic [COORD_W-1:0]   rb;
        logic [COORD_W-1:0]   cb;
        logic [2*COORD_W-1:0] spot;
        bit                   can_hit;
        bit                   bad;
        bit                   found;
        int                   pick;
        int                   stretch;

        can_hit = rows_eff > 0 && cols_eff > 0;
        bad = !can_hit ||
              ((rows_eff < GRID_EDGE || cols_eff < GRID_EDGE) && $urandom_range(9, 0) == 0);
        // Unused fields carry noise so that every bit toggles.
        ra = COORD_W'($urandom());
        ca = COORD_W'($urandom());
        rb = COORD_W'($urandom());
        cb = COORD_W'($urandom());
        pick = $urandom_range(99, 0);
        if (pick < 28)
            op = MODE_WRITE;
        else if (pick < 34)
            op = MODE_PUSH;
        else if (pick < 36)
            op = MODE_UNUSED;
        else
            op = MODE_READ;

        if (op == MODE_PUSH)
        begin
            if (can_hit)
            begin
                ra = pick_inside(rows_eff);
                ca = pick_inside(cols_eff);
                if ($urandom_range(2, 0) != 0)
                begin
                    // Small rectangles leave enough of the grid uncovered for base reads.
                    stretch = int'(ra) + $urandom_range(3, 0);
                    rb = COORD_W'((stretch > rows_eff - 1) ? rows_eff - 1 : stretch);
                    stretch = int'(ca) + $urandom_range(3, 0);
                    cb = COORD_W'((stretch > cols_eff - 1) ? cols_eff - 1 : stretch);
                end
                else
                begin
                    rb = pick_inside(rows_eff);
                    cb = pick_inside(cols_eff);
                end
                if (bad)
                begin
                    if ($urandom_range(1, 0) == 1)
                        outside_pair(ra, ca);
                    else
                        outside_pair(rb, cb);
                end
            end
            else
            begin
                outside_pair(ra, ca);
                outside_pair(rb, cb);
            end
        end
        else if (op != MODE_UNUSED)
        begin
            if (bad)
                outside_pair(ra, ca);
            else
            begin
                ra = pick_inside(rows_eff);
                ca = pick_inside(cols_eff);
            end
        end

        // An in-range read only goes to a cell that holds a value; failing that it writes one.
        if (op == MODE_READ && !bad)
        begin
            found = 1'b0;
            for (int tries = 0; tries < 4 && !found && written_cells.size() > 0; tries++)
            begin
                spot = written_cells[$urandom_range(written_cells.size() - 1, 0)];
                if (fits_now(spot[2*COORD_W-1:COORD_W], spot[COORD_W-1:0]))
                    found = 1'b1;
            end
            if (found)
            begin
                ra = spot[2*COORD_W-1:COORD_W];
                ca = spot[COORD_W-1:0];
            end
            else
                op = MODE_WRITE;
        end

        send_beat(op, ra, ca, rb, cb, random_word());
    endtask

    task automatic run_phase(input int rows, input int cols, input int beats);
        configure(rows, cols);
        for (int n = 0; n < beats; n++)
        begin
            random_beat();
            sender_pause();
            if ($urandom_range(249, 0) == 0)
                wait_drained();
        end
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    // Receiver: short random stalls, open stretches, and one long hold-off that backs
    // the block up into its input.
    initial
    begin
        int open_len;
        int shut_len;
        bit held_long;
        held_long = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (!held_long && beats_sent >= HOLD_AT_BEAT)
            begin
                held_long = 1'b1;
                @(negedge clk);
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(negedge clk);
            end
            open_len = ($urandom_range(9, 0) == 0) ? $urandom_range(60, 20)
                                                   : $urandom_range(8, 1);
            repeat (open_len)
            begin
                @(negedge clk);
                out_stall <= 1'b0;
            end
            shut_len = ($urandom_range(9, 0) == 0) ? $urandom_range(30, 6)
                                                   : $urandom_range(3, 1);
            repeat (shut_len)
            begin
                @(negedge clk);
                out_stall <= 1'b1;
            end
        end
    end

    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel || !rst_n)
                quiet = 0;
            else
                quiet++;
        end
        $display("watchdog: no beat accepted for %0d cycles", WATCHDOG_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        logic [COORD_W-1:0] fill_row;
        logic [COORD_W-1:0] fill_col;

        @(posedge rst_n);
        configure(64, 64);

        // Corner cells with extreme values, then overlapping and inverted rectangles.
        send_beat(MODE_WRITE, 6'd0, 6'd0, TOP_COORD, 6'd0, 32'h8000_0000);
        send_beat(MODE_WRITE, TOP_COORD, TOP_COORD, 6'd0, TOP_COORD, 32'h7FFF_FFFF);
        send_beat(MODE_WRITE, 6'd0, TOP_COORD, TOP_COORD, TOP_COORD, 32'hFFFF_FFFF);
        send_beat(MODE_WRITE, TOP_COORD, 6'd0, 6'd0, 6'd0, 32'h0000_0000);
        send_beat(MODE_WRITE, 6'd5, 6'd5, 6'd9, 6'd9, 32'h1234_5678);
        send_beat(MODE_WRITE, 6'd62, TOP_COORD, 6'd0, 6'd0, 32'h0F0F_0F0F);
        send_beat(MODE_READ, 6'd0, 6'd0, 6'd0, 6'd0, 32'h0000_0000);
        send_beat(MODE_READ, TOP_COORD, TOP_COORD, TOP_COORD, TOP_COORD, 32'hFFFF_FFFF);
        send_beat(MODE_PUSH, 6'd60, 6'd60, TOP_COORD, TOP_COORD, 32'h8000_0000);
        send_beat(MODE_READ, TOP_COORD, TOP_COORD, 6'd0, 6'd0, 32'h0000_0000);
        send_beat(MODE_PUSH, 6'd62, 6'd62, 6'd62, TOP_COORD, 32'h7FFF_FFFF);
        send_beat(MODE_READ, 6'd62, TOP_COORD, 6'd0, 6'd0, 32'h0000_0000);
        send_beat(MODE_READ, TOP_COORD, TOP_COORD, 6'd0, 6'd0, 32'h0000_0000);
        send_beat(MODE_PUSH, 6'd10, 6'd0, 6'd5, TOP_COORD, 32'h0000_0001);
        send_beat(MODE_PUSH, 6'd0, 6'd40, TOP_COORD, 6'd20, 32'hFFFF_FFFE);
        send_beat(MODE_READ, 6'd5, 6'd5, 6'd0, 6'd0, 32'h0000_0000);
        send_beat(MODE_READ, 6'd0, TOP_COORD, 6'd0, 6'd0, 32'h0000_0000);
        send_beat(MODE_UNUSED, TOP_COORD, TOP_COORD, TOP_COORD, TOP_COORD, 32'hFFFF_FFFF);
        send_beat(MODE_UNUSED, 6'd0, 6'd0, 6'd0, 6'd0, 32'h0000_0000);
        send_beat(MODE_PUSH, 6'd0, 6'd0, 6'd0, 6'd0, 32'hDEAD_BEEF);
        send_beat(MODE_READ, 6'd0, 6'd0, 6'd0, 6'd0, 32'h0000_0000);

        // A single cell in use: everything else is out of range, on either corner.
        configure(1, 1);
        send_beat(MODE_WRITE, 6'd1, 6'd0, 6'd0, 6'd0, 32'h0000_00AA);
        send_beat(MODE_WRITE, 6'd0, 6'd1, 6'd0, 6'd0, 32'h0000_00BB);
        send_beat(MODE_READ, 6'd0, 6'd5, 6'd0, 6'd0, 32'h0000_0000);
        send_beat(MODE_PUSH, 6'd0, 6'd0, 6'd0, 6'd1, 32'h0000_0011);
        send_beat(MODE_PUSH, 6'd3, 6'd0, 6'd0, 6'd0, 32'h0000_0022);
        send_beat(MODE_READ, 6'd0, 6'd0, 6'd0, 6'd0, 32'h0000_0000);

        run_phase(1, 1, 80);
        run_phase(127, 100, 350);
        run_phase(0, 5, 40);
        run_phase(8, 8, 450);
        run_phase(33, 17, 600);

        // Make sure the log has filled and later pushes are turned away.
        while (rects_logged < LOG_DEF + 3)
        begin
            fill_row = pick_inside(rows_eff);
            fill_col = pick_inside(cols_eff);
            send_beat(MODE_PUSH, fill_row, fill_col, fill_row, fill_col, random_word());
            sender_pause();
        end
        for (int n = 0; n < 20; n++)
            random_beat();

        wait_drained();
        repeat (6) @(posedge clk);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

>>> sim.f
+incdir+design
design/rog_pkg.sv
design/rog_ram.sv
design/rog_cell.sv
design/rectangle_overlay_grid.sv
design/rog_checker.sv
tb/sv/rectangle_overlay_grid_checker.sv
tb/sv/rectangle_overlay_grid_test.sv
